/* src/bmm_pkg.sv */
`default_nettype none
package bmm_pkg;
  localparam int unsigned WordBits = 64;
  localparam int unsigned FieldBits = 64;
  localparam int unsigned CfgIdxBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_MOD_LO = 3'd0,
    REG_MOD_HI = 3'd1,
    REG_RECIP0 = 3'd2,
    REG_RECIP1 = 3'd3,
    REG_RECIP2 = 3'd4
  } cfg_reg_e;
endpackage
`default_nettype wire

/* src/barrett_modmul_two_word.sv */
`default_nettype none
// Two-word Barrett modular multiplier: product = first * second mod n.
// Input channel: in_valid_i / in_stall_o with operand words first_* and
// second_*. Output channel: out_valid_o / out_stall_i with product_*.
// Config channel: cfg_valid_i / cfg_ready_o, cfg_index_i selects modulus
// low/high (0,1) or reciprocal words (2..4); other indexes are ignored.
// Write config only while no items are in flight.
// The datapath is a chain of multiply-accumulate cells, one half-word by
// half-word partial product per cell: 16 for b*c, 36 for the reciprocal
// estimate, 16 for q*n, then one stage for the subtract and one for the
// two conditional subtracts of n. It takes one item per cycle while no
// finished item is held at the output.
// When the receiver stalls a valid result, the whole chain holds and the
// input stalls, so no item is lost. Reset empties the chain and loads
// n = 2^W + 1 and a zero reciprocal.
module barrett_modmul_two_word #(
  parameter int unsigned WORD_BITS = bmm_pkg::WordBits
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [bmm_pkg::FieldBits-1:0] first_high_i,
  input  wire logic [bmm_pkg::FieldBits-1:0] first_low_i,
  input  wire logic [bmm_pkg::FieldBits-1:0] second_high_i,
  input  wire logic [bmm_pkg::FieldBits-1:0] second_low_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [bmm_pkg::FieldBits-1:0]    product_high_o,
  output logic [bmm_pkg::FieldBits-1:0]    product_low_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [bmm_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [bmm_pkg::FieldBits-1:0] cfg_data_i
);
  import bmm_pkg::*;
  localparam int unsigned W = WORD_BITS;
  // half-word digit; each cell multiplies one digit pair
  localparam int unsigned D = (W + 1) / 2;
  localparam int unsigned NX = 16;
  localparam int unsigned NZ = 36;
  localparam int unsigned NQ = 16;

  logic [W-1:0] mod_lo_q, mod_hi_q, rc0_q, rc1_q, rc2_q;
  logic         en;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_lo_q <= W'(1);
      mod_hi_q <= W'(1);
      rc0_q    <= '0;
      rc1_q    <= '0;
      rc2_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MOD_LO: mod_lo_q <= cfg_data_i[W-1:0];
        REG_MOD_HI: mod_hi_q <= cfg_data_i[W-1:0];
        REG_RECIP0: rc0_q    <= cfg_data_i[W-1:0];
        REG_RECIP1: rc1_q    <= cfg_data_i[W-1:0];
        REG_RECIP2: rc2_q    <= cfg_data_i[W-1:0];
        default: ;
      endcase
    end
  end

  // chain advances unless a finished item is held at the output
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // stage 1: x = b*c, 4 word products of 4 digit cells each
  localparam int unsigned XW = 4*W;
  logic [W-1:0]  ba [2];
  logic [W-1:0]  ca [2];
  assign ba[0] = first_low_i[W-1:0];
  assign ba[1] = first_high_i[W-1:0];
  assign ca[0] = second_low_i[W-1:0];
  assign ca[1] = second_high_i[W-1:0];

  logic          xv [NX+1];
  logic [XW-1:0] xa [NX+1];
  logic [4*W-1:0] xc [NX+1];
  assign xv[0] = in_valid_i;
  assign xa[0] = '0;
  assign xc[0] = {ca[1], ca[0], ba[1], ba[0]};

  for (genvar k = 0; k < NX; k++) begin : g_x
    localparam int unsigned M = k / 4;
    localparam int unsigned I = M / 2;
    localparam int unsigned J = M % 2;
    localparam int unsigned P = (k % 4) / 2;
    localparam int unsigned S = k % 2;
    logic [2*D-1:0] aw, bw;
    assign aw = (2*D)'(xc[k][I*W +: W]);
    assign bw = (2*D)'(xc[k][(2+J)*W +: W]);
    bmm_mac_cell #(.W(D), .ACC(XW), .SH((I+J)*W + (P+S)*D), .CW(4*W)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .vld_i(xv[k]),
      .a_i(aw[P*D +: D]), .b_i(bw[S*D +: D]),
      .acc_i(xa[k]), .ctx_i(xc[k]),
      .vld_o(xv[k+1]), .acc_o(xa[k+1]), .ctx_o(xc[k+1])
    );
  end

  // stage 2: z = (x>>W)*ninv mod 2^5W, all 9 word products, 4 digit
  // cells each
  localparam int unsigned ZW = 5*W;
  logic          zv [NZ+1];
  logic [ZW-1:0] za [NZ+1];
  logic [XW-1:0] zc [NZ+1];
  assign zv[0] = xv[NX];
  assign za[0] = '0;
  assign zc[0] = xa[NX];

  for (genvar k = 0; k < NZ; k++) begin : g_z
    localparam int unsigned M = k / 4;
    localparam int unsigned I = M / 3;
    localparam int unsigned J = M % 3;
    localparam int unsigned P = (k % 4) / 2;
    localparam int unsigned S = k % 2;
    logic [W-1:0]   rw;
    logic [2*D-1:0] aw, bw;
    assign rw = (J == 0) ? rc0_q : ((J == 1) ? rc1_q : rc2_q);
    assign aw = (2*D)'(zc[k][(I+1)*W +: W]);
    assign bw = (2*D)'(rw);
    bmm_mac_cell #(.W(D), .ACC(ZW), .SH((I+J)*W + (P+S)*D), .CW(XW)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .vld_i(zv[k]),
      .a_i(aw[P*D +: D]), .b_i(bw[S*D +: D]),
      .acc_i(za[k]), .ctx_i(zc[k]),
      .vld_o(zv[k+1]), .acc_o(za[k+1]), .ctx_o(zc[k+1])
    );
  end

  // stage 3: q = (z>>3W)*n mod 2^3W, all 4 word products (the high by
  // high product still reaches the third word), 4 digit cells each
  localparam int unsigned QW = 3*W;
  logic          qv [NQ+1];
  logic [QW-1:0] qa [NQ+1];
  logic [XW+2*W-1:0] qc [NQ+1];
  assign qv[0] = zv[NZ];
  assign qa[0] = '0;
  assign qc[0] = {za[NZ][4*W +: W], za[NZ][3*W +: W], zc[NZ]};

  for (genvar k = 0; k < NQ; k++) begin : g_q
    localparam int unsigned M = k / 4;
    localparam int unsigned I = M / 2;
    localparam int unsigned J = M % 2;
    localparam int unsigned P = (k % 4) / 2;
    localparam int unsigned S = k % 2;
    logic [W-1:0]   nw;
    logic [2*D-1:0] aw, bw;
    assign nw = (J == 0) ? mod_lo_q : mod_hi_q;
    assign aw = (2*D)'(qc[k][XW + I*W +: W]);
    assign bw = (2*D)'(nw);
    bmm_mac_cell #(.W(D), .ACC(QW), .SH((I+J)*W + (P+S)*D), .CW(XW+2*W)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .vld_i(qv[k]),
      .a_i(aw[P*D +: D]), .b_i(bw[S*D +: D]),
      .acc_i(qa[k]), .ctx_i(qc[k]),
      .vld_o(qv[k+1]), .acc_o(qa[k+1]), .ctx_o(qc[k+1])
    );
  end

  // subtract stage: r = x - q mod 2^3W
  logic          rv_q;
  logic [QW-1:0] r_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else if (en) begin
      rv_q <= qv[NQ];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q <= qc[NQ][QW-1:0] - qa[NQ];
    end
  end

  // final correction: up to two subtractions of n
  logic [QW-1:0] n3, d1, d2, res;
  assign n3 = {{W{1'b0}}, mod_hi_q, mod_lo_q};
  assign d1 = r_q - n3;
  assign d2 = d1 - n3;
  always_comb begin
    if (!d1[QW-1]) begin
      res = d2[QW-1] ? d1 : d2;
    end else begin
      res = r_q;
    end
  end

  logic         ov_q;
  logic [W-1:0] oh_q, ol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= rv_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      oh_q <= res[W +: W];
      ol_q <= res[W-1:0];
    end
  end

  assign out_valid_o    = ov_q;
  assign product_high_o = FieldBits'(oh_q);
  assign product_low_o  = FieldBits'(ol_q);
endmodule
`default_nettype wire

/* src/bmm_mac_cell.sv */
`default_nettype none
// One cell of the multiply chain: adds one W-bit by W-bit partial product
// into a running accumulator and hands the item on to the next cell.
module bmm_mac_cell #(
  parameter int unsigned W   = 64,
  parameter int unsigned ACC = 320,
  parameter int unsigned SH  = 0,
  parameter int unsigned CW  = 256
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           vld_i,
  input  wire logic [W-1:0]   a_i,
  input  wire logic [W-1:0]   b_i,
  input  wire logic [ACC-1:0] acc_i,
  input  wire logic [CW-1:0]  ctx_i,
  output logic                vld_o,
  output logic [ACC-1:0]      acc_o,
  output logic [CW-1:0]       ctx_o
);
  logic [2*W-1:0] prod;
  logic [ACC-1:0] term;
  logic           vld_q;
  logic [ACC-1:0] acc_q;
  logic [CW-1:0]  ctx_q;

  // partial product at its word position, truncated to the accumulator
  assign prod = {{W{1'b0}}, a_i} * {{W{1'b0}}, b_i};
  assign term = ACC'({{ACC{1'b0}}, prod} << SH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_i + term;
      ctx_q <= ctx_i;
    end
  end

  assign vld_o = vld_q;
  assign acc_o = acc_q;
  assign ctx_o = ctx_q;
endmodule
`default_nettype wire

/* src/bmm_checker.sv */
`default_nettype none
// Port-level checks on the top level.
module bmm_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic [63:0] product_high_o,
  input wire logic [63:0] product_low_o
);
  // input is stalled exactly when a held result waits
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i)) else $error("stall mismatch");
  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(product_low_o)
    && $stable(product_high_o)) else $error("result changed under stall");
  // no result right after reset release without input history
  a_rst: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o) else $error("valid after reset");
  // handshake signals are always known out of reset
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_valid_i, in_stall_o, out_valid_o})) else $error("unknown handshake");
endmodule

bind barrett_modmul_two_word bmm_checker u_bmm_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .product_high_o, .product_low_o
);
`default_nettype wire
